FILE: design/best_fit_allocator_coalescing_core_macros.svh
// Assertion helpers shared by the allocator core.
`ifndef BEST_FIT_ALLOCATOR_COALESCING_CORE_MACROS_SVH
`define BEST_FIT_ALLOCATOR_COALESCING_CORE_MACROS_SVH

// Same-cycle implication.
`define BFAC_ASSERT_SAME(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) else $error(msg);

// Next-cycle implication.
`define BFAC_ASSERT_NEXT(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) else $error(msg);

`endif

FILE: design/bfac_pkg.sv
`timescale 1ns / 1ps

package bfac_pkg;

   localparam int PAGE_BYTES   = 4096;
   localparam int HEADER_BYTES = 24;
   localparam int FREE_DEPTH   = 64;
   localparam int LIVE_DEPTH   = 64;
   localparam int MAX_PAGES    = 256;
   localparam int ALIGN_BYTES  = 8;

   localparam int ADDR_W     = 20;
   localparam int PAGES_W    = 9;
   localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
   localparam int ALIGN_SH   = $clog2(ALIGN_BYTES);
   localparam int SUM_W      = $clog2(MAX_PAGES * PAGE_BYTES) + 2;
   localparam int FADDR_W    = $clog2(FREE_DEPTH);
   localparam int FCNT_W     = $clog2(FREE_DEPTH + 1);
   localparam int LADDR_W    = $clog2(LIVE_DEPTH);
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_ADDR_W-3:0] REG_REGION = '0;

   localparam logic REQ_ALLOC = 1'b0;
   localparam logic REQ_FREE  = 1'b1;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_NO_SPACE = 2'd1,
      ST_UNKNOWN  = 2'd2,
      ST_FULL     = 2'd3
   } status_code_type;

   typedef struct packed {
      logic              req_type;
      logic [ADDR_W-1:0] alloc_bytes;
      logic [ADDR_W-1:0] block_offset;
      logic              coalesce;
   } bfac_req_type;

   typedef struct packed {
      status_code_type   status;
      logic [ADDR_W-1:0] payload_offset;
   } bfac_rsp_type;

   typedef struct packed {
      logic [ADDR_W-1:0] start;
      logic [ADDR_W-1:0] usable;
   } extent_type;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_INIT,
      OP_LOAD,
      OP_LREAD,
      OP_LCHECK,
      OP_FCLEAR,
      OP_FREAD,
      OP_FCHECK,
      OP_REMOVE,
      OP_SPLIT,
      OP_DREAD,
      OP_DWRITE,
      OP_DEC,
      OP_LWRITE,
      OP_PREAD,
      OP_PCHECK,
      OP_PSET,
      OP_UREAD,
      OP_UWRITE,
      OP_INSERT,
      OP_MREAD0,
      OP_MFIRST,
      OP_MREAD,
      OP_MCHECK,
      OP_MEND,
      OP_DONE
   } dp_op_type;

   typedef struct packed {
      dp_op_type       op;
      status_code_type code;
   } dp_cmd_type;

   typedef struct packed {
      logic is_free;
      logic off_zero;
      logic live_hit;
      logic live_last;
      logic table_full;
      logic scan_more;
      logic found;
      logic exact;
      logic small_left;
      logic before_blk;
      logic up_more;
      logic coalesce;
      logic rsp_free;
   } dp_stat_type;

endpackage

FILE: design/best_fit_allocator_coalescing_core.sv
`timescale 1ns / 1ps
// Channel   Direction  Ports
// req       in         req_valid, req_stall, req_data
// rsp       out        rsp_valid, rsp_stall, rsp_data
// csr       in/out     csr_psel, csr_penable, csr_pwrite, csr_paddr, csr_pwdata, csr_prdata,
//                      csr_pready
// A transaction searches the live slots (up to LIVE_DEPTH), then visits the free
// extents for the best-fit scan or insert search, shifts extents on removal or
// insertion, and walks the extents on the coalescing pass.
// Every free-extent step goes through the single read port of the free-extent memory.
// Reset and each region_pages write rebuild the first extent in the INIT state.
// The result register lets the next transaction run while a result is stalled.

`include "best_fit_allocator_coalescing_core_macros.svh"

module best_fit_allocator_coalescing_core
   import bfac_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  bfac_req_type          req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output bfac_rsp_type          rsp_data,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   dp_cmd_type         cmd;
   dp_stat_type        stat;
   logic               busy;
   logic               cfg_wr;
   logic [PAGES_W-1:0] region;
   logic               reg_hit;

   assign csr_pready = 1'b1;
   assign reg_hit    = (csr_paddr[CSR_ADDR_W-1:2] == REG_REGION);
   assign cfg_wr     = csr_psel && csr_penable && csr_pwrite && reg_hit;
   assign csr_prdata = reg_hit ? CSR_DATA_W'(region) : '0;
   assign req_stall  = busy;

   bfac_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .cfg_wr    (cfg_wr),
      .stat      (stat),
      .cmd       (cmd),
      .busy      (busy)
   );

   bfac_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_data  (req_data),
      .cfg_wr    (cfg_wr),
      .cfg_pages (csr_pwdata[PAGES_W-1:0]),
      .rsp_stall (rsp_stall),
      .region    (region),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   `BFAC_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall, "accepted transaction did not block the next")
   `BFAC_ASSERT_SAME(a_fail_no_offset, clock, reset, rsp_valid && (rsp_data.status != ST_OK), rsp_data.payload_offset == '0, "failed transaction carries an offset")
   `BFAC_ASSERT_SAME(a_offset_past_header, clock, reset, rsp_valid && (rsp_data.payload_offset != '0), rsp_data.payload_offset >= ADDR_W'(HEADER_BYTES), "payload offset inside a header")

endmodule

FILE: design/bfac_ctrl.sv
`timescale 1ns / 1ps

module bfac_ctrl
   import bfac_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        cfg_wr,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd,
   output logic        busy
);

   typedef enum logic [4:0] {
      S_INIT, S_IDLE, S_LREAD, S_LCHECK, S_FSTART, S_FREAD, S_FCHECK, S_CHOOSE,
      S_DREAD, S_DWRITE, S_LWRITE, S_PSTART, S_PREAD, S_PCHECK, S_UREAD,
      S_UWRITE, S_MSTART, S_MFIRST, S_MREAD, S_MCHECK, S_DONE
   } state_type;

   state_type       state_ff, state_in;
   status_code_type code_ff, code_in;

   always_comb begin
      state_in = state_ff;
      code_in  = code_ff;
      cmd.op   = OP_NONE;
      cmd.code = code_ff;
      unique case (state_ff)
         S_INIT: begin
            cmd.op   = OP_INIT;
            state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               state_in = S_LREAD;
            end
         end
         S_LREAD: begin
            if (stat.is_free && stat.off_zero) begin
               code_in  = ST_OK;
               state_in = S_DONE;
            end else begin
               cmd.op   = OP_LREAD;
               state_in = S_LCHECK;
            end
         end
         S_LCHECK: begin
            cmd.op = OP_LCHECK;
            priority if (stat.live_hit && !stat.is_free) begin
               state_in = S_FSTART;
            end else if (stat.live_hit && stat.table_full) begin
               code_in  = ST_FULL;
               state_in = S_DONE;
            end else if (stat.live_hit) begin
               state_in = S_PSTART;
            end else if (stat.live_last) begin
               code_in  = stat.is_free ? ST_UNKNOWN : ST_FULL;
               state_in = S_DONE;
            end else begin
               state_in = S_LREAD;
            end
         end
         S_FSTART: begin
            cmd.op   = OP_FCLEAR;
            state_in = S_FREAD;
         end
         S_FREAD: begin
            priority if (stat.scan_more) begin
               cmd.op   = OP_FREAD;
               state_in = S_FCHECK;
            end else if (stat.found) begin
               state_in = S_CHOOSE;
            end else begin
               code_in  = ST_NO_SPACE;
               state_in = S_DONE;
            end
         end
         S_FCHECK: begin
            cmd.op   = OP_FCHECK;
            state_in = stat.exact ? S_CHOOSE : S_FREAD;
         end
         S_CHOOSE: begin
            if (stat.small_left) begin
               cmd.op   = OP_REMOVE;
               state_in = S_DREAD;
            end else begin
               cmd.op   = OP_SPLIT;
               state_in = S_LWRITE;
            end
         end
         S_DREAD: begin
            if (stat.scan_more) begin
               cmd.op   = OP_DREAD;
               state_in = S_DWRITE;
            end else begin
               cmd.op   = OP_DEC;
               state_in = S_LWRITE;
            end
         end
         S_DWRITE: begin
            cmd.op   = OP_DWRITE;
            state_in = S_DREAD;
         end
         S_LWRITE: begin
            cmd.op   = OP_LWRITE;
            code_in  = ST_OK;
            state_in = S_DONE;
         end
         S_PSTART: begin
            cmd.op   = OP_FCLEAR;
            state_in = S_PREAD;
         end
         S_PREAD: begin
            if (stat.scan_more) begin
               cmd.op   = OP_PREAD;
               state_in = S_PCHECK;
            end else begin
               cmd.op   = OP_PSET;
               state_in = S_UREAD;
            end
         end
         S_PCHECK: begin
            cmd.op   = OP_PCHECK;
            state_in = stat.before_blk ? S_PREAD : S_UREAD;
         end
         S_UREAD: begin
            priority if (stat.up_more) begin
               cmd.op   = OP_UREAD;
               state_in = S_UWRITE;
            end else if (stat.coalesce) begin
               cmd.op   = OP_INSERT;
               state_in = S_MSTART;
            end else begin
               cmd.op   = OP_INSERT;
               code_in  = ST_OK;
               state_in = S_DONE;
            end
         end
         S_UWRITE: begin
            cmd.op   = OP_UWRITE;
            state_in = S_UREAD;
         end
         S_MSTART: begin
            cmd.op   = OP_MREAD0;
            state_in = S_MFIRST;
         end
         S_MFIRST: begin
            cmd.op   = OP_MFIRST;
            state_in = S_MREAD;
         end
         S_MREAD: begin
            if (stat.scan_more) begin
               cmd.op   = OP_MREAD;
               state_in = S_MCHECK;
            end else begin
               cmd.op   = OP_MEND;
               code_in  = ST_OK;
               state_in = S_DONE;
            end
         end
         S_MCHECK: begin
            cmd.op   = OP_MCHECK;
            state_in = S_MREAD;
         end
         S_DONE: begin
            if (stat.rsp_free) begin
               cmd.op   = OP_DONE;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_INIT;
         end
      endcase
      if (cfg_wr) begin
         cmd.op   = OP_NONE;
         state_in = S_INIT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         code_ff  <= ST_OK;
      end else begin
         state_ff <= state_in;
         code_ff  <= code_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule

FILE: design/bfac_datapath.sv
`timescale 1ns / 1ps

module bfac_datapath
   import bfac_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  dp_cmd_type           cmd,
   input  bfac_req_type         req_data,
   input  logic                 cfg_wr,
   input  logic [PAGES_W-1:0]   cfg_pages,
   input  logic                 rsp_stall,
   output logic [PAGES_W-1:0]   region,
   output dp_stat_type          stat,
   output logic                 rsp_valid,
   output bfac_rsp_type         rsp_data
);

   extent_type             fmem [FREE_DEPTH];
   extent_type             lmem [LIVE_DEPTH];
   extent_type             frd_ff, lrd_ff;

   logic [PAGES_W-1:0]     region_ff;
   logic [FCNT_W-1:0]      fcount_ff;
   logic [LIVE_DEPTH-1:0]  live_vld_ff;
   bfac_req_type           req_ff;
   logic [SUM_W-1:0]       total_ff;
   logic [LADDR_W-1:0]     lidx_ff, slot_ff;
   logic [ADDR_W-1:0]      blk_start_ff, blk_us_ff;
   logic [FCNT_W-1:0]      fidx_ff, pos_ff, w_ff;
   logic [FADDR_W-1:0]     best_ff;
   logic [ADDR_W-1:0]      best_start_ff, best_us_ff;
   logic                   found_ff;
   extent_type             cur_ff;
   logic                   rsp_vld_ff;
   bfac_rsp_type           rsp_ff;

   logic [PAGES_W-1:0]     pages;
   logic [SUM_W-1:0]       init_sum, total_raw, span, best_span, best_left, adj_end;
   logic [ADDR_W-1:0]      init_usable, split_us, live_off, blk_off;
   logic [FCNT_W-1:0]      fidx_dec;
   logic                   exact, greater, better, live_hit, adjacent;
   logic [FADDR_W-1:0]     frd_addr, fwr_addr;
   logic                   fwe;
   extent_type             fwr_data;

   always_comb begin
      priority if (region_ff == '0) begin
         pages = PAGES_W'(1);
      end else if (region_ff > PAGES_W'(MAX_PAGES)) begin
         pages = PAGES_W'(MAX_PAGES);
      end else begin
         pages = region_ff;
      end
   end

   assign init_sum    = (SUM_W'(pages) << PAGE_SHIFT) - SUM_W'(HEADER_BYTES);
   assign init_usable = init_sum[ADDR_W-1:0];
   assign total_raw   = SUM_W'(HEADER_BYTES) + SUM_W'(req_data.alloc_bytes)
                        + SUM_W'(ALIGN_BYTES - 1);
   assign span        = SUM_W'(frd_ff.usable) + SUM_W'(HEADER_BYTES);
   assign exact       = (span == total_ff);
   assign greater     = (span > total_ff);
   assign better      = exact || (greater && (!found_ff || (frd_ff.usable < best_us_ff)));
   assign best_span   = SUM_W'(best_us_ff) + SUM_W'(HEADER_BYTES);
   assign best_left   = best_span - total_ff;
   assign split_us    = best_us_ff - total_ff[ADDR_W-1:0];
   assign live_off    = lrd_ff.start + ADDR_W'(HEADER_BYTES);
   assign blk_off     = blk_start_ff + ADDR_W'(HEADER_BYTES);
   assign adj_end     = SUM_W'(cur_ff.start) + SUM_W'(HEADER_BYTES) + SUM_W'(cur_ff.usable);
   assign adjacent    = (adj_end == SUM_W'(frd_ff.start));
   assign fidx_dec    = fidx_ff - FCNT_W'(1);
   assign live_hit    = (req_ff.req_type == REQ_FREE)
                        ? (live_vld_ff[lidx_ff] && (live_off == req_ff.block_offset))
                        : !live_vld_ff[lidx_ff];

   always_comb begin
      frd_addr = fidx_ff[FADDR_W-1:0];
      fwe      = 1'b0;
      fwr_addr = fidx_ff[FADDR_W-1:0];
      fwr_data = frd_ff;
      unique case (cmd.op)
         OP_UREAD:  frd_addr = fidx_dec[FADDR_W-1:0];
         OP_MREAD0: frd_addr = '0;
         OP_INIT: begin
            fwe      = 1'b1;
            fwr_addr = '0;
            fwr_data = '{start: '0, usable: init_usable};
         end
         OP_SPLIT: begin
            fwe      = 1'b1;
            fwr_addr = best_ff;
            fwr_data = '{start: best_start_ff, usable: split_us};
         end
         OP_DWRITE: begin
            fwe      = 1'b1;
            fwr_addr = fidx_dec[FADDR_W-1:0];
         end
         OP_UWRITE: begin
            fwe = 1'b1;
         end
         OP_INSERT: begin
            fwe      = 1'b1;
            fwr_addr = pos_ff[FADDR_W-1:0];
            fwr_data = '{start: blk_start_ff, usable: blk_us_ff};
         end
         OP_MCHECK: begin
            fwe      = !adjacent;
            fwr_addr = w_ff[FADDR_W-1:0];
            fwr_data = cur_ff;
         end
         OP_MEND: begin
            fwe      = 1'b1;
            fwr_addr = w_ff[FADDR_W-1:0];
            fwr_data = cur_ff;
         end
         default: begin
            fwe = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      frd_ff <= fmem[frd_addr];
      if (fwe) begin
         fmem[fwr_addr] <= fwr_data;
      end
   end

   always_ff @(posedge clock) begin
      lrd_ff <= lmem[lidx_ff];
      if (cmd.op == OP_LWRITE) begin
         lmem[slot_ff] <= '{start: blk_start_ff, usable: blk_us_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         region_ff   <= PAGES_W'(1);
         fcount_ff   <= FCNT_W'(1);
         live_vld_ff <= '0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         if (cfg_wr) begin
            region_ff   <= cfg_pages;
            live_vld_ff <= '0;
         end
         if (cmd.op == OP_DONE) begin
            rsp_vld_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_vld_ff <= 1'b0;
         end
         unique case (cmd.op)
            OP_INIT: fcount_ff <= FCNT_W'(1);
            OP_LOAD: begin
               req_ff   <= req_data;
               total_ff <= {total_raw[SUM_W-1:ALIGN_SH], ALIGN_SH'(0)};
               lidx_ff  <= '0;
            end
            OP_LCHECK: begin
               if (live_hit) begin
                  slot_ff      <= lidx_ff;
                  blk_start_ff <= lrd_ff.start;
                  blk_us_ff    <= lrd_ff.usable;
               end else begin
                  lidx_ff <= lidx_ff + LADDR_W'(1);
               end
            end
            OP_FCLEAR: begin
               fidx_ff  <= '0;
               found_ff <= 1'b0;
            end
            OP_FCHECK: begin
               if (better) begin
                  best_ff       <= fidx_ff[FADDR_W-1:0];
                  best_start_ff <= frd_ff.start;
                  best_us_ff    <= frd_ff.usable;
                  found_ff      <= 1'b1;
               end
               fidx_ff <= fidx_ff + FCNT_W'(1);
            end
            OP_REMOVE: begin
               blk_start_ff <= best_start_ff;
               blk_us_ff    <= best_us_ff;
               fidx_ff      <= FCNT_W'(best_ff) + FCNT_W'(1);
            end
            OP_SPLIT: begin
               blk_start_ff <= best_start_ff + ADDR_W'(HEADER_BYTES) + split_us;
               blk_us_ff    <= total_ff[ADDR_W-1:0] - ADDR_W'(HEADER_BYTES);
            end
            OP_DWRITE: fidx_ff <= fidx_ff + FCNT_W'(1);
            OP_DEC:    fcount_ff <= fcount_ff - FCNT_W'(1);
            OP_LWRITE: live_vld_ff[slot_ff] <= 1'b1;
            OP_PCHECK: begin
               if (frd_ff.start < blk_start_ff) begin
                  fidx_ff <= fidx_ff + FCNT_W'(1);
               end else begin
                  pos_ff  <= fidx_ff;
                  fidx_ff <= fcount_ff;
               end
            end
            OP_PSET:   pos_ff <= fidx_ff;
            OP_UWRITE: fidx_ff <= fidx_dec;
            OP_INSERT: begin
               fcount_ff            <= fcount_ff + FCNT_W'(1);
               live_vld_ff[slot_ff] <= 1'b0;
            end
            OP_MFIRST: begin
               cur_ff  <= frd_ff;
               fidx_ff <= FCNT_W'(1);
               w_ff    <= '0;
            end
            OP_MCHECK: begin
               if (adjacent) begin
                  cur_ff.usable <= cur_ff.usable + frd_ff.usable + ADDR_W'(HEADER_BYTES);
               end else begin
                  cur_ff <= frd_ff;
                  w_ff   <= w_ff + FCNT_W'(1);
               end
               fidx_ff <= fidx_ff + FCNT_W'(1);
            end
            OP_MEND: fcount_ff <= w_ff + FCNT_W'(1);
            OP_DONE: begin
               rsp_ff.status         <= cmd.code;
               rsp_ff.payload_offset <= (req_ff.req_type == REQ_ALLOC && cmd.code == ST_OK)
                                        ? blk_off : '0;
            end
            default: begin
               rsp_ff <= rsp_ff;
            end
         endcase
      end
   end

   always_comb begin
      stat.is_free    = (req_ff.req_type == REQ_FREE);
      stat.off_zero   = (req_ff.block_offset == '0);
      stat.live_hit   = live_hit;
      stat.live_last  = (lidx_ff == LADDR_W'(LIVE_DEPTH - 1));
      stat.table_full = (fcount_ff >= FCNT_W'(FREE_DEPTH));
      stat.scan_more  = (fidx_ff < fcount_ff);
      stat.found      = found_ff;
      stat.exact      = exact;
      stat.small_left = (best_left < SUM_W'(HEADER_BYTES));
      stat.before_blk = (frd_ff.start < blk_start_ff);
      stat.up_more    = (fidx_ff > pos_ff);
      stat.coalesce   = req_ff.coalesce;
      stat.rsp_free   = !rsp_vld_ff || !rsp_stall;
   end

   assign region    = region_ff;
   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import bfac_pkg::*;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   bfac_req_type          req_data;
   logic                  rsp_valid;
   logic                  rsp_stall;
   bfac_rsp_type          rsp_data;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   best_fit_allocator_coalescing_core i_dut (.*);

   // allocator shadow state
   int unsigned ext_start [FREE_DEPTH];
   int unsigned ext_size  [FREE_DEPTH];
   int unsigned ext_count;
   int unsigned blk_start [LIVE_DEPTH];
   int unsigned blk_size  [LIVE_DEPTH];
   bit          blk_live  [LIVE_DEPTH];
   int unsigned pages_cfg;

   bfac_rsp_type expected_rsp_q[$];
   int           fail_count;
   bit           idle_en;
   int           hold_req;
   int           stall_left;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #200ms;
      $display("== FAIL ==");
      $finish;
   end

   task automatic report(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      fail_count++;
   endtask

   function automatic void reset_tables();
      for (int i = 0; i < FREE_DEPTH; i++) begin
         ext_start[i] = 0;
         ext_size[i]  = 0;
      end
      for (int i = 0; i < LIVE_DEPTH; i++) begin
         blk_start[i] = 0;
         blk_size[i]  = 0;
         blk_live[i]  = 1'b0;
      end
      ext_size[0] = pages_cfg * PAGE_BYTES - HEADER_BYTES;
      ext_count   = 1;
   endfunction

   function automatic void drop_extent(int unsigned idx);
      for (int unsigned i = idx; i + 1 < ext_count; i++) begin
         ext_start[i] = ext_start[i+1];
         ext_size[i]  = ext_size[i+1];
      end
      ext_count--;
   endfunction

   function automatic bfac_rsp_type allocator_result(bfac_req_type r);
      bfac_rsp_type res;
      int unsigned  total, span, best, bst, bus, slot, pos;
      bit           found;
      res.status         = ST_OK;
      res.payload_offset = '0;
      found = 1'b0;
      best  = 0;
      slot  = LIVE_DEPTH;
      if (r.req_type == REQ_ALLOC) begin
         total = (HEADER_BYTES + int'(r.alloc_bytes) + 7) & ~32'd7;
         for (int i = 0; i < LIVE_DEPTH; i++)
            if (!blk_live[i] && slot == LIVE_DEPTH) slot = i;
         if (slot == LIVE_DEPTH) begin
            res.status = ST_FULL;
            return res;
         end
         for (int unsigned i = 0; i < ext_count; i++) begin
            span = ext_size[i] + HEADER_BYTES;
            if (span == total) begin
               best  = i;
               found = 1'b1;
               break;
            end
            if (span > total && (!found || ext_size[i] < ext_size[best])) begin
               best  = i;
               found = 1'b1;
            end
         end
         if (!found) begin
            res.status = ST_NO_SPACE;
            return res;
         end
         span = ext_size[best] + HEADER_BYTES;
         if (span - total < HEADER_BYTES) begin
            bst = ext_start[best];
            bus = ext_size[best];
            drop_extent(best);
         end else begin
            ext_size[best] -= total;
            bst = ext_start[best] + HEADER_BYTES + ext_size[best];
            bus = total - HEADER_BYTES;
         end
         blk_start[slot] = bst;
         blk_size[slot]  = bus;
         blk_live[slot]  = 1'b1;
         res.payload_offset = ADDR_W'(bst + HEADER_BYTES);
      end else begin
         if (r.block_offset == '0) return res;
         for (int i = 0; i < LIVE_DEPTH; i++)
            if (blk_live[i] && slot == LIVE_DEPTH
                && ADDR_W'(blk_start[i] + HEADER_BYTES) == r.block_offset) slot = i;
         if (slot == LIVE_DEPTH) begin
            res.status = ST_UNKNOWN;
            return res;
         end
         if (ext_count >= FREE_DEPTH) begin
            res.status = ST_FULL;
            return res;
         end
         pos = 0;
         while (pos < ext_count && ext_start[pos] < blk_start[slot]) pos++;
         for (int unsigned i = ext_count; i > pos; i--) begin
            ext_start[i] = ext_start[i-1];
            ext_size[i]  = ext_size[i-1];
         end
         ext_start[pos] = blk_start[slot];
         ext_size[pos]  = blk_size[slot];
         ext_count++;
         blk_live[slot] = 1'b0;
         if (r.coalesce) begin
            pos = 0;
            while (pos + 1 < ext_count) begin
               if (ext_start[pos] + HEADER_BYTES + ext_size[pos] == ext_start[pos+1]) begin
                  ext_size[pos] += ext_size[pos+1] + HEADER_BYTES;
                  drop_extent(pos + 1);
               end else begin
                  pos++;
               end
            end
         end
      end
      return res;
   endfunction

   // receiver stall bursts and long hold-offs
   initial begin
      rsp_stall  = 1'b1;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (hold_req > 0) begin
            stall_left = hold_req;
            hold_req   = 0;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (idle_en && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 14);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      bfac_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsp_q.size() == 0) begin
            report("result with no request outstanding");
         end else begin
            want = expected_rsp_q.pop_front();
            if (rsp_data.status !== want.status)
               report($sformatf("status %0d, expected %0d", rsp_data.status, want.status));
            if (rsp_data.payload_offset !== want.payload_offset)
               report($sformatf("offset %h, expected %h",
                                rsp_data.payload_offset, want.payload_offset));
         end
      end
   end

   task automatic send(bfac_req_type r);
      req_data  <= r;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      expected_rsp_q.push_back(allocator_result(r));
      @(negedge clock);
      if (idle_en && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(negedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (expected_rsp_q.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic set_region(int unsigned pages);
      drain();
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {REG_REGION, 2'b00};
      csr_pwdata  <= pages;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      pages_cfg = pages;
      reset_tables();
      @(negedge clock);
      csr_pwrite  <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata[PAGES_W-1:0] !== PAGES_W'(pages))
         report($sformatf("region_pages read %0d, expected %0d", csr_prdata, pages));
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      repeat (4) @(negedge clock);
   endtask

   function automatic bfac_req_type make_req(logic kind, int unsigned bytes,
                                            int unsigned offset, logic merge);
      bfac_req_type r;
      r.req_type     = kind;
      r.alloc_bytes  = ADDR_W'(bytes);
      r.block_offset = ADDR_W'(offset);
      r.coalesce     = merge;
      return r;
   endfunction

   function automatic int unsigned some_live_offset();
      int unsigned pick;
      int          n;
      n = 0;
      for (int i = 0; i < LIVE_DEPTH; i++) if (blk_live[i]) n++;
      if (n == 0) return 0;
      pick = $urandom_range(0, n - 1);
      for (int i = 0; i < LIVE_DEPTH; i++)
         if (blk_live[i]) begin
            if (pick == 0) return (blk_start[i] + HEADER_BYTES) & 32'hFFFFF;
            pick--;
         end
      return 0;
   endfunction

   function automatic bfac_req_type random_req();
      bfac_req_type r;
      int unsigned  sel, off;
      r   = make_req(REQ_ALLOC, $urandom, $urandom, $urandom_range(0, 3) != 0);
      sel = $urandom_range(0, 99);
      if (sel < 50) begin
         case ($urandom_range(0, 9))
            0:       r.alloc_bytes = ADDR_W'($urandom);
            1, 2:    r.alloc_bytes = ADDR_W'($urandom_range(0, 9000));
            default: r.alloc_bytes = ADDR_W'($urandom_range(0, 400));
         endcase
      end else begin
         r.req_type = REQ_FREE;
         off = some_live_offset();
         if (sel < 88 && off != 0)      r.block_offset = ADDR_W'(off);
         else if (sel < 92 && off != 0) r.block_offset = ADDR_W'(off + 8);
         else if (sel < 96)             r.block_offset = '0;
      end
      return r;
   endfunction

   task automatic test_directed();
      set_region(1);
      send(make_req(REQ_ALLOC, 0, 20'hFFFFF, 1'b1));
      send(make_req(REQ_ALLOC, 20'hFFFFF, 0, 1'b0));
      send(make_req(REQ_FREE, 20'hFFFFF, 0, 1'b1));
      send(make_req(REQ_FREE, 0, 20'hFFFFF, 1'b0));
      send(make_req(REQ_FREE, 0, 4096 - 8, 1'b1));
      send(make_req(REQ_FREE, 0, 4096 - 8, 1'b1));
      send(make_req(REQ_ALLOC, 4000, 0, 1'b0));
      send(make_req(REQ_ALLOC, 4072, 0, 1'b0));
      set_region(1);
      send(make_req(REQ_ALLOC, 4072, 0, 1'b0));
      send(make_req(REQ_FREE, 0, HEADER_BYTES, 1'b0));
      send(make_req(REQ_ALLOC, 4056, 0, 1'b0));
      send(make_req(REQ_FREE, 0, HEADER_BYTES, 1'b1));
      send(make_req(REQ_ALLOC, 100, 0, 1'b0));
      send(make_req(REQ_ALLOC, 37, 0, 1'b0));
      send(make_req(REQ_FREE, 0, some_live_offset(), 1'b0));
      send(make_req(REQ_FREE, 0, some_live_offset(), 1'b1));
      set_region(256);
      send(make_req(REQ_ALLOC, 20'hFFFFF, 0, 1'b0));
      send(make_req(REQ_ALLOC, 1048552, 0, 1'b0));
      send(make_req(REQ_FREE, 0, HEADER_BYTES, 1'b1));
   endtask

   task automatic test_tables_full();
      set_region(1);
      repeat (LIVE_DEPTH + 2) send(make_req(REQ_ALLOC, 8, 0, 1'b0));
      repeat (LIVE_DEPTH + 2) send(make_req(REQ_FREE, 0, some_live_offset(), 1'b0));
      send(make_req(REQ_FREE, 0, some_live_offset(), 1'b1));
      drain();
   endtask

   task automatic test_backpressure();
      set_region(2);
      hold_req = 1500;
      repeat (40) send(random_req());
      drain();
   endtask

   task automatic test_random(int unsigned count, int unsigned pages);
      set_region(pages);
      repeat (count) send(random_req());
   endtask

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      fail_count  = 0;
      idle_en     = 1'b1;
      hold_req    = 0;
      pages_cfg   = 1;
      reset_tables();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      repeat (4) @(negedge clock);

      test_directed();
      test_tables_full();
      test_backpressure();
      test_random(300, 1);
      test_random(300, 256);
      test_random(300, $urandom_range(2, 255));
      test_random(250, 3);
      idle_en = 1'b0;
      test_random(150, $urandom_range(1, 256));
      drain();
      repeat (20) @(posedge clock);
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
